@@ src/opr_pkg.sv @@
`default_nettype none
package opr_pkg;

	localparam int DEFAULT_DEPTH = 64;

	localparam int REQ_W   = 3;
	localparam int IDX_W   = 6;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 7;
	localparam int ENTRY_W = 2 * WORD_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 3'd0,
		REQ_POP   = 3'd1,
		REQ_READ  = 3'd2,
		REQ_WRITE = 3'd3,
		REQ_CLEAR = 3'd4
	} req_t;

	// store access for one beat
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

	// result fields settled at accept time
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               error;
		logic               hit;
	} res_t;

endpackage
`default_nettype wire

@@ src/opr_store.sv @@
`default_nettype none
module opr_store
	import opr_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire mem_cmd_t           cmd,
	input  wire logic [AW-1:0]      addr,
	input  wire logic [ENTRY_W-1:0] wdata,
	output logic      [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	// write one entry per beat
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

@@ src/opr_ctrl.sv @@
`default_nettype none
module opr_ctrl
	import opr_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [REQ_W-1:0] req,
	input  wire logic [IDX_W-1:0] idx,
	output mem_cmd_t              cmd,
	output logic      [AW-1:0]    addr,
	output res_t                  res
);

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [AW-1:0] start_q;
	logic [CW-1:0] fill_q;

	logic [AW-1:0]    start_d;
	logic [CW-1:0]    fill_d;
	logic [CW-1:0]    off;
	logic [CW:0]      sum;
	logic [CW:0]      sum_w;
	logic [CW:0]      inc;
	logic [CW:0]      inc_w;
	logic [AW-1:0]    slot;
	logic [AW-1:0]    start_inc;
	logic [CMP_W-1:0] idx_x;
	logic [CMP_W-1:0] fill_x;
	logic             full;
	logic             empty;
	logic             idx_ok;
	req_t             rq;

	assign rq     = req_t'(req);
	assign full   = (fill_q == DEPTH_C);
	assign empty  = (fill_q == '0);
	assign idx_x  = CMP_W'(idx);
	assign fill_x = CMP_W'(fill_q);
	assign idx_ok = (idx_x < fill_x);

	// slot = (start + offset) mod DEPTH; for every access that reaches the store the sum stays below twice the depth
	always_comb begin
		unique case (rq) inside
			REQ_PUSH:             off = full ? '0 : fill_q;
			REQ_POP:              off = fill_q - CW'(1);
			REQ_READ, REQ_WRITE:  off = idx_x[CW-1:0];
			default:              off = '0;
		endcase
	end

	assign sum   = (CW + 1)'(start_q) + {1'b0, off};
	assign sum_w = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
	assign slot  = sum_w[AW-1:0];

	// oldest slot advanced by one, for a push into a full ring
	assign inc       = (CW + 1)'(start_q) + (CW + 1)'(1);
	assign inc_w     = (inc >= DEPTH_S) ? (inc - DEPTH_S) : inc;
	assign start_inc = inc_w[AW-1:0];

	// decode the request into state update, store access and result
	always_comb begin
		start_d   = start_q;
		fill_d    = fill_q;
		cmd       = '0;
		res.error = 1'b0;
		res.hit   = 1'b0;
		unique case (rq)
			REQ_PUSH: begin
				cmd.wr = 1'b1;
				if (full) begin
					start_d = start_inc;
				end else begin
					fill_d = fill_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (empty) begin
					res.error = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					res.hit = 1'b1;
					fill_d  = fill_q - CW'(1);
				end
			end
			REQ_READ: begin
				if (idx_ok) begin
					cmd.rd  = 1'b1;
					res.hit = 1'b1;
				end else begin
					res.error = 1'b1;
				end
			end
			REQ_WRITE: begin
				if (idx_ok) begin
					cmd.wr = 1'b1;
				end else begin
					res.error = 1'b1;
				end
			end
			REQ_CLEAR: begin
				start_d = '0;
				fill_d  = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			cmd = '0;
		end
		res.count = COUNT_W'(fill_d);
	end

	assign addr = slot;

	// update pointer and count on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			start_q <= start_d;
			fill_q  <= fill_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rq == REQ_CLEAR |=> fill_q == '0 && start_q == '0)
		else $error("clear left entries");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rq == REQ_PUSH && full |=> full && start_q != $past(start_q)
			|| DEPTH == 1)
		else $error("push into full ring did not drop oldest");

	a_no_dual: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr && cmd.rd) && (!cmd.wr && !cmd.rd || accept))
		else $error("store access without a single accepted beat");

endmodule
`default_nettype wire

@@ src/overwriting_position_ring.sv @@
`default_nettype none
// Overwriting position ring: a history of up to DEPTH (x, y) word pairs.
// Requests enter on the s_ stream: s_tuser carries the request code (push,
// pop newest, read at index, write at index, clear), s_tdata the index and
// the two coordinate words. Each request yields exactly one result beat on
// the m_ stream: m_tdata carries x, y and the count after the request,
// m_tuser the error flag (pop on empty, index not below count). x and y are
// zero unless the request returned an entry.
// A request is presented on m_ in the cycle after it is accepted. One
// request per cycle is sustained while the receiver keeps up; the single output
// register and the one-access store set that figure. The store sees at most
// one access per beat, read data is registered and forms the output data.
// When the receiver stalls, the result is held and s_tready drops until the
// result is taken (s_tready follows m_tready combinationally).
// Reset clears the ring pointer, the count and the output valid; store
// contents are not cleared and are never read before being written.
module overwriting_position_ring
	import opr_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [5:0] index, [37:6] x_in, [69:38] y_in, [71:70] zero
	input  wire logic [71:0] s_tdata,
	// [2:0] req_type
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] x_out, [63:32] y_out, [70:64] count, [71] zero
	output logic      [71:0] m_tdata,
	// [0] error
	output logic      [0:0]  m_tuser
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               accept;
	mem_cmd_t           cmd;
	logic [AW-1:0]      addr;
	res_t               res;
	res_t               res_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [WORD_W-1:0]  x_out;
	logic [WORD_W-1:0]  y_out;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign wdata    = {s_tdata[69:38], s_tdata[37:6]};

	opr_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (s_tuser),
		.idx    (s_tdata[5:0]),
		.cmd    (cmd),
		.addr   (addr),
		.res    (res)
	);

	opr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.cmd   (cmd),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	// zero the words unless an entry was returned
	assign x_out = res_q.hit ? rdata[WORD_W-1:0] : '0;
	assign y_out = res_q.hit ? rdata[ENTRY_W-1:WORD_W] : '0;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.count, y_out, x_out};
	assign m_tuser  = res_q.error;

endmodule
`default_nettype wire
